/* src/mx4_pkg.sv */
// mx4_pkg: shared types and fixed port widths for the 4x4 matrix multiplier.
// No dependencies.
`default_nettype none

package mx4_pkg;

  // Port field widths fixed by the item format
  localparam int IN_W  = 32;
  localparam int OUT_W = 32;
  localparam int POS_W = 2;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;   // zero the accumulator
    logic mul_en;  // capture a new product
    logic acc_en;  // add the rescaled product into the accumulator
  } mac_ctl_t;

endpackage

`default_nettype wire

/* src/mx4_ram.sv */
// mx4_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mx4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/mx4_mac.sv */
// mx4_mac: shared multiply-accumulate unit with floor rescale and saturation.
// Depends on mx4_pkg (mac_ctl_t).
`default_nettype none

module mx4_mac
  import mx4_pkg::*;
#(
  parameter int DIM       = 4,
  parameter int ELEM_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire mac_ctl_t                    ctl,
  input  wire logic signed [ELEM_BITS-1:0] a,
  input  wire logic signed [ELEM_BITS-1:0] b,
  output logic signed      [ELEM_BITS-1:0] sat
);

  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int PSH_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W  = PSH_W + $clog2(DIM) + 1;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - ELEM_BITS + 1){1'b0}}, {(ELEM_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [PSH_W-1:0]  prod_rs;

  // arithmetic shift rounds toward minus infinity
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign prod_rs = prod_sh[PSH_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_rs);
    end
  end

  always_comb begin
    if (acc_r > SAT_HI) begin
      sat = SAT_HI[ELEM_BITS-1:0];
    end else if (acc_r < SAT_LO) begin
      sat = SAT_LO[ELEM_BITS-1:0];
    end else begin
      sat = acc_r[ELEM_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

/* src/matrix4_multiply.sv */
// matrix4_multiply: streaming DIM x DIM fixed-point matrix multiplier, top level.
// Depends on mx4_pkg, mx4_ram (operand stores) and mx4_mac (shared MAC unit).
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_ready, in_elem_value               | in
//  result  | out_valid, out_ready, out_prod_value, out_row,  | out
//          | out_col, out_last_elem                          |
//  config  | cfg_we, cfg_wdata (transpose_out)               | in
//
// Loading accepts one item per cycle: 2*DIM*DIM items fill both stores.
// Each result cell is then computed on the single MAC (DIM reads, the RAM
// read register, multiply register, accumulate), followed by the output handshake.
// A stalled result holds the sequencer; no input is taken until all DIM*DIM
// results of a run are delivered. Synchronous reset clears the control state.
`default_nettype none

module matrix4_multiply
  import mx4_pkg::*;
#(
  parameter int DIM       = 4,
  parameter int ELEM_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [IN_W-1:0]   in_elem_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OUT_W-1:0]       out_prod_value,
  output logic [POS_W-1:0]       out_row,
  output logic [POS_W-1:0]       out_col,
  output logic                   out_last_elem,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(2 * CELLS);
  localparam int IW    = $clog2(DIM);

  typedef enum logic [1:0] {
    S_LOAD,
    S_CALC,
    S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   load_cnt_r, load_cnt_nxt;
  logic [IW-1:0]   row_r, row_nxt;
  logic [IW-1:0]   col_r, col_nxt;
  logic [IW-1:0]   k_r, k_nxt;
  logic            issue_r, issue_nxt;
  logic            rd_v_r, rd_last_r;
  logic            mul_v_r, mul_last_r;
  logic            acc_done_r;
  logic            out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] prod_r, prod_nxt;
  logic [POS_W-1:0] orow_r, orow_nxt;
  logic [POS_W-1:0] ocol_r, ocol_nxt;
  logic            olast_r, olast_nxt;
  logic            transpose_r;

  logic                  in_acc;
  logic                  left_we, right_we;
  logic [AW-1:0]         left_waddr, right_waddr;
  logic [AW-1:0]         left_raddr, right_raddr;
  logic [IW-1:0]         lrow, rcol;
  logic [ELEM_BITS-1:0]  wdata;
  logic [ELEM_BITS-1:0]  left_rdata, right_rdata;
  logic signed [ELEM_BITS-1:0] mac_sat;
  logic                  last_k, last_cell;
  mac_ctl_t              mac_ctl;

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign wdata     = in_elem_value[ELEM_BITS-1:0];

  assign left_we     = in_acc && (load_cnt_r < CW'(CELLS));
  assign right_we    = in_acc && (load_cnt_r >= CW'(CELLS));
  assign left_waddr  = load_cnt_r[AW-1:0];
  assign right_waddr = AW'(load_cnt_r - CW'(CELLS));

  // transposed output swaps which operand row/column a cell draws on
  assign lrow        = transpose_r ? col_r : row_r;
  assign rcol        = transpose_r ? row_r : col_r;
  assign left_raddr  = AW'(lrow) * AW'(DIM) + AW'(k_r);
  assign right_raddr = AW'(k_r) * AW'(DIM) + AW'(rcol);

  assign last_k    = (k_r == IW'(DIM - 1));
  assign last_cell = (row_r == IW'(DIM - 1)) && (col_r == IW'(DIM - 1));

  assign mac_ctl.clear  = issue_r && (k_r == '0);
  assign mac_ctl.mul_en = rd_v_r;
  assign mac_ctl.acc_en = mul_v_r;

  mx4_ram #(.WIDTH(ELEM_BITS), .DEPTH(CELLS)) u_left (
    .clk   (clk),
    .we    (left_we),
    .waddr (left_waddr),
    .wdata (wdata),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  mx4_ram #(.WIDTH(ELEM_BITS), .DEPTH(CELLS)) u_right (
    .clk   (clk),
    .we    (right_we),
    .waddr (right_waddr),
    .wdata (wdata),
    .raddr (right_raddr),
    .rdata (right_rdata)
  );

  mx4_mac #(.DIM(DIM), .ELEM_BITS(ELEM_BITS), .FRAC_BITS(FRAC_BITS)) u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (left_rdata),
    .b   (right_rdata),
    .sat (mac_sat)
  );

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    issue_nxt     = issue_r;
    out_valid_nxt = out_valid_r;
    prod_nxt      = prod_r;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    olast_nxt     = olast_r;

    if (issue_r) begin
      k_nxt = k_r + IW'(1);
      if (last_k) begin
        k_nxt     = '0;
        issue_nxt = 1'b0;
      end
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          load_cnt_nxt = load_cnt_r + CW'(1);
          if (load_cnt_r == CW'(2 * CELLS - 1)) begin
            load_cnt_nxt = '0;
            row_nxt      = '0;
            col_nxt      = '0;
            k_nxt        = '0;
            issue_nxt    = 1'b1;
            state_nxt    = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (acc_done_r) begin
          out_valid_nxt = 1'b1;
          prod_nxt      = OUT_W'(mac_sat);
          orow_nxt      = POS_W'(row_r);
          ocol_nxt      = POS_W'(col_r);
          olast_nxt     = last_cell;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (last_cell) begin
            state_nxt = S_LOAD;
          end else begin
            if (col_r == IW'(DIM - 1)) begin
              col_nxt = '0;
              row_nxt = row_r + IW'(1);
            end else begin
              col_nxt = col_r + IW'(1);
            end
            k_nxt     = '0;
            issue_nxt = 1'b1;
            state_nxt = S_CALC;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      k_r         <= '0;
      issue_r     <= 1'b0;
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      mul_v_r     <= 1'b0;
      mul_last_r  <= 1'b0;
      acc_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
      transpose_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      k_r         <= k_nxt;
      issue_r     <= issue_nxt;
      // read, multiply, accumulate pipeline markers
      rd_v_r      <= issue_r;
      rd_last_r   <= issue_r && last_k;
      mul_v_r     <= rd_v_r;
      mul_last_r  <= rd_v_r && rd_last_r;
      acc_done_r  <= mul_v_r && mul_last_r;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        transpose_r <= cfg_wdata;
      end
    end
    prod_r  <= prod_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_prod_value = prod_r;
  assign out_row        = orow_r;
  assign out_col        = ocol_r;
  assign out_last_elem  = olast_r;

endmodule

`default_nettype wire

/* tb/sv/tb_matrix4_multiply.sv */
// tb_matrix4_multiply: self-checking bench for the streaming 4x4 Q16.16 matrix multiplier.
// Depends on mx4_pkg and matrix4_multiply. Predicts every product element and checks value,
// position and last marker under random idling on both channels and one long output stall.
module tb_matrix4_multiply;
  import mx4_pkg::*;

  localparam int DIM          = 4;
  localparam int CELLS        = DIM * DIM;
  localparam int FRAC_BITS    = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;
  localparam longint SAT_HI   = 64'sd2147483647;
  localparam longint SAT_LO   = -64'sd2147483648;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } prod_elem_t;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic [IN_W-1:0]  in_elem_value = '0;
  logic             out_ready     = 1'b0;
  logic             cfg_we        = 1'b0;
  logic             cfg_wdata     = 1'b0;
  wire              in_ready;
  wire              out_valid;
  wire [OUT_W-1:0]  out_prod_value;
  wire [POS_W-1:0]  out_row;
  wire [POS_W-1:0]  out_col;
  wire              out_last_elem;

  logic [IN_W-1:0]  elem_pending [$];
  prod_elem_t       prod_expected [$];

  // bench copy of the operand stores and the output-order bit
  logic signed [IN_W-1:0] left_m  [CELLS];
  logic signed [IN_W-1:0] right_m [CELLS];
  int               loaded        = 0;
  logic             xpose         = 1'b0;

  logic             in_acc        = 1'b0;
  int               tx_idle_pct   = 0;
  int               rx_idle_pct   = 0;
  logic             hold_arm      = 1'b0;
  logic             hold_used     = 1'b0;
  int               rx_hold_left  = 0;

  int               cycle_cnt     = 0;
  int               items_taken   = 0;
  int               runs_done     = 0;
  int               results_seen  = 0;
  int               mismatches    = 0;

  // extremes on both signs, saturation both ways, floor rounding of tiny negatives
  logic [IN_W-1:0]  corner_pair [2*CELLS] = '{
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
    32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
    32'h0000_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h5555_5555,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0001_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h0001_0000
  };

  matrix4_multiply u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_elem_value  (in_elem_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prod_value (out_prod_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_last_elem  (out_last_elem),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // one element of A*B: exact products, floor rescale, 4-term sum, clamp to 32 bits
  function automatic logic [OUT_W-1:0] cell_value(int r, int c);
    longint acc;
    acc = 0;
    for (int k = 0; k < DIM; k++)
      acc += (longint'(left_m[r*DIM+k]) * longint'(right_m[k*DIM+c])) >>> FRAC_BITS;
    if (acc > SAT_HI)
      acc = SAT_HI;
    else if (acc < SAT_LO)
      acc = SAT_LO;
    return acc[OUT_W-1:0];
  endfunction

  task automatic absorb_elem(input logic [IN_W-1:0] v);
    prod_elem_t e;
    if (loaded < CELLS)
      left_m[loaded] = v;
    else
      right_m[loaded-CELLS] = v;
    loaded++;
    items_taken++;
    if (loaded == 2*CELLS) begin
      loaded = 0;
      runs_done++;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          e.value = xpose ? cell_value(c, r) : cell_value(r, c);
          e.row   = POS_W'(r);
          e.col   = POS_W'(c);
          e.last  = (r == DIM-1) && (c == DIM-1);
          prod_expected.push_back(e);
        end
      end
    end
  endtask

  function automatic logic [IN_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      // within +-8.0
      2, 3, 4, 5, 6: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      // within +-256.0
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  task automatic queue_random_runs(input int n);
    repeat (n * 2 * CELLS) elem_pending.push_back(rand_elem());
  endtask

  task automatic write_transpose(input logic v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_drained();
    while (elem_pending.size() != 0 || in_valid || prod_expected.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // input side: track acceptance and feed the predictor
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && in_ready;
    if (!rst_n) begin
      loaded = 0;
      xpose  = 1'b0;
    end else begin
      if (cfg_we)
        xpose = cfg_wdata;
      if (in_valid && in_ready)
        absorb_elem(in_elem_value);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (elem_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid      <= 1'b1;
        in_elem_value <= elem_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: random ready, plus one long hold-off once armed
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_arm && !hold_used) begin
      out_ready    <= 1'b0;
      rx_hold_left <= HOLD_CYCLES;
      hold_used    <= 1'b1;
    end else begin
      out_ready <= $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  always @(posedge clk) begin
    prod_elem_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.value = out_prod_value;
      got.row   = out_row;
      got.col   = out_col;
      got.last  = out_last_elem;
      if (prod_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: value %h row %0d col %0d last %0b",
                   got.value, got.row, got.col, got.last);
      end else begin
        want = prod_expected.pop_front();
        results_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch at result %0d: expected %h r%0d c%0d last %0b, got %h r%0d c%0d last %0b",
                     results_seen, want.value, want.row, want.col, want.last,
                     got.value, got.row, got.col, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, prod_expected.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // slow receiver, light sender gaps
    write_transpose(1'b0);
    tx_idle_pct = 20;
    rx_idle_pct = 60;
    foreach (corner_pair[i]) elem_pending.push_back(corner_pair[i]);
    queue_random_runs(1);
    wait_drained();

    write_transpose(1'b1);
    tx_idle_pct = 60;
    rx_idle_pct = 20;
    foreach (corner_pair[i]) elem_pending.push_back(corner_pair[i]);
    queue_random_runs(1);
    wait_drained();

    // full rate, with the long stall so the input backs up
    write_transpose(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_runs(2);
    hold_arm = 1'b1;
    wait_drained();

    write_transpose(1'b1);
    queue_random_runs(1);
    wait_drained();

    mismatches += prod_expected.size();
    $display("covered %0d element items in %0d matrix products, %0d product elements checked,",
             items_taken, runs_done, results_seen);
    $display("both output orders, corner operands, idling on both sides and a long result stall");
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
